// ===== hw/rtl/tplpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tplpq_pkg
// Shared types and constants of the three-level priority queue with expiry:
// operation and status codes, level codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tplpq_pkg;

  // field widths fixed by the interface
  localparam int unsigned ModeW    = 2;
  localparam int unsigned IdW      = 16;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned TurnW    = 8;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned ExpiredW = 5;
  localparam int unsigned NonEmptyW = 2;

  // priority levels
  localparam logic [LevelW-1:0] LvlHigh   = 2'd0;
  localparam logic [LevelW-1:0] LvlMedium = 2'd1;
  localparam logic [LevelW-1:0] LvlLow    = 2'd2;
  localparam logic [LevelW-1:0] LvlSpare  = 2'd3;

  // operation codes
  typedef enum logic [ModeW-1:0] {
    MODE_ADD  = 2'd0,
    MODE_TAKE = 2'd1,
    MODE_TICK = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TAKE_WAIT,
    S_TICK_RD,
    S_TICK_WR,
    S_RESP
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // latch the transaction fields
    logic exec;      // run the decoded operation
    logic take_cap;  // capture dequeued identifier
    logic tick_rd;   // read next high entry
    logic tick_wr;   // keep or drop the entry just read
    logic tick_fin;  // close the tick walk
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    mode_e mode;
    logic  take_hit;  // some level holds an entry
    logic  tick_end;  // all high entries visited
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tplpq_ram.sv =====
// ----------------------------------------------------------------------------
// tplpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tplpq_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tplpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tplpq_ctrl
// Controller state machine: decodes a transaction, sequences the take read
// and the tick walk, and marks the result cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tplpq_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  output logic                     valid_o,
  input  wire tplpq_pkg::dp_stat_t stat_i,
  output tplpq_pkg::cmd_t          cmd_o
);

  tplpq_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tplpq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    valid_o = 1'b0;
    case (state_q)
      tplpq_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = tplpq_pkg::S_DECODE;
        end
      end
      tplpq_pkg::S_DECODE: begin
        cmd_o.exec = 1'b1;
        case (stat_i.mode)
          tplpq_pkg::MODE_TAKE: begin
            state_d = stat_i.take_hit ? tplpq_pkg::S_TAKE_WAIT : tplpq_pkg::S_RESP;
          end
          tplpq_pkg::MODE_TICK: state_d = tplpq_pkg::S_TICK_RD;
          default:              state_d = tplpq_pkg::S_RESP;
        endcase
      end
      tplpq_pkg::S_TAKE_WAIT: begin
        cmd_o.take_cap = 1'b1;
        state_d        = tplpq_pkg::S_RESP;
      end
      tplpq_pkg::S_TICK_RD: begin
        if (stat_i.tick_end) begin
          cmd_o.tick_fin = 1'b1;
          state_d        = tplpq_pkg::S_RESP;
        end else begin
          cmd_o.tick_rd = 1'b1;
          state_d       = tplpq_pkg::S_TICK_WR;
        end
      end
      tplpq_pkg::S_TICK_WR: begin
        cmd_o.tick_wr = 1'b1;
        state_d       = tplpq_pkg::S_TICK_RD;
      end
      tplpq_pkg::S_RESP: begin
        valid_o = 1'b1;
        busy    = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = tplpq_pkg::S_DECODE;
        end else begin
          state_d = tplpq_pkg::S_IDLE;
        end
      end
      default: state_d = tplpq_pkg::S_IDLE;
    endcase
  end

  // result strobe lasts one cycle
  a_resp_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tplpq_pkg::S_RESP) |=>
      (state_q == tplpq_pkg::S_IDLE || state_q == tplpq_pkg::S_DECODE))
    else $error("result state held longer than one cycle");

  // a tick walk always alternates read and keep/drop steps
  a_tick_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tplpq_pkg::S_TICK_WR) |-> ($past(state_q) == tplpq_pkg::S_TICK_RD))
    else $error("tick write step without a preceding read");

endmodule

`default_nettype wire

// ===== hw/rtl/tplpq_dp.sv =====
// ----------------------------------------------------------------------------
// tplpq_dp
// Datapath: the three level stores, head and fill registers, tick walk
// counters and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tplpq_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tplpq_pkg::cmd_t                   cmd_i,
  output tplpq_pkg::dp_stat_t                    stat_o,
  input  wire logic [tplpq_pkg::ModeW-1:0]       mode_i,
  input  wire logic [tplpq_pkg::IdW-1:0]         item_id_i,
  input  wire logic [tplpq_pkg::LevelW-1:0]      level_i,
  input  wire logic [tplpq_pkg::TurnW-1:0]       turns_allowed_i,
  output logic      [tplpq_pkg::StatusW-1:0]     status_o,
  output logic      [tplpq_pkg::IdW-1:0]         taken_id_o,
  output logic      [tplpq_pkg::ExpiredW-1:0]    expired_count_o,
  output logic      [tplpq_pkg::NonEmptyW-1:0]   nonempty_levels_o
);

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned HW = tplpq_pkg::IdW + tplpq_pkg::TurnW;
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DepthS = (CW+1)'(QUEUE_DEPTH);

  // circular index add, base below depth and offset at most depth
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= DepthS) begin
      s = s - DepthS;
    end
    return s[IW-1:0];
  endfunction

  // transaction fields
  tplpq_pkg::mode_e            mode_q;
  logic [tplpq_pkg::IdW-1:0]   id_q;
  logic [tplpq_pkg::LevelW-1:0] lvl_q;
  logic [tplpq_pkg::TurnW-1:0] turns_q;

  // queue bookkeeping
  logic [IW-1:0] head_q [3];
  logic [IW-1:0] head_d [3];
  logic [CW-1:0] count_q [3];
  logic [CW-1:0] count_d [3];

  // take and tick bookkeeping
  logic [tplpq_pkg::LevelW-1:0] sel_q, sel_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] kept_q, kept_d;
  logic [CW-1:0] drop_q, drop_d;

  // results
  tplpq_pkg::status_e              status_q, status_d;
  logic [tplpq_pkg::IdW-1:0]       taken_q, taken_d;
  logic [tplpq_pkg::ExpiredW-1:0]  expired_q, expired_d;

  // ram ports
  logic          hi_we, md_we, lo_we;
  logic [IW-1:0] hi_waddr, hi_raddr, add_slot;
  logic [HW-1:0] hi_wdata, hi_rdata;
  logic [tplpq_pkg::IdW-1:0] md_rdata, lo_rdata;

  logic                         add_full, add_ok;
  logic [tplpq_pkg::LevelW-1:0] take_sel;
  logic                         take_hit;
  logic                         rd_expired;
  logic [tplpq_pkg::TurnW-1:0]  rd_turns;

  // latch transaction fields, spare level maps to low
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= tplpq_pkg::mode_e'(mode_i);
      id_q    <= item_id_i;
      lvl_q   <= (level_i == tplpq_pkg::LvlSpare) ? tplpq_pkg::LvlLow : level_i;
      turns_q <= turns_allowed_i;
    end
  end

  // add and take decode
  assign add_full = (count_q[lvl_q] == DepthC);
  assign add_ok   = cmd_i.exec && (mode_q == tplpq_pkg::MODE_ADD) && !add_full;
  assign add_slot = wrap_add(head_q[lvl_q], count_q[lvl_q]);

  always_comb begin
    take_hit = 1'b1;
    if (count_q[0] != '0) begin
      take_sel = tplpq_pkg::LvlHigh;
    end else if (count_q[1] != '0) begin
      take_sel = tplpq_pkg::LvlMedium;
    end else begin
      take_sel = tplpq_pkg::LvlLow;
      take_hit = (count_q[2] != '0);
    end
  end

  // tick entry just read
  assign rd_turns   = hi_rdata[tplpq_pkg::TurnW-1:0];
  assign rd_expired = (rd_turns <= tplpq_pkg::TurnW'(1));

  // high store ports
  always_comb begin
    hi_we    = 1'b0;
    hi_waddr = add_slot;
    hi_wdata = {id_q, turns_q};
    if (add_ok && (lvl_q == tplpq_pkg::LvlHigh)) begin
      hi_we = 1'b1;
    end else if (cmd_i.tick_wr && !rd_expired) begin
      hi_we    = 1'b1;
      hi_waddr = wrap_add(head_q[0], kept_q);
      hi_wdata = {hi_rdata[HW-1:tplpq_pkg::TurnW], rd_turns - tplpq_pkg::TurnW'(1)};
    end
  end

  assign hi_raddr = cmd_i.tick_rd ? wrap_add(head_q[0], idx_q) : head_q[0];
  assign md_we    = add_ok && (lvl_q == tplpq_pkg::LvlMedium);
  assign lo_we    = add_ok && (lvl_q == tplpq_pkg::LvlLow);

  tplpq_ram #(.Width(HW), .Depth(QUEUE_DEPTH)) u_high_ram (
    .clk_i   (clk_i),
    .we_i    (hi_we),
    .waddr_i (hi_waddr),
    .wdata_i (hi_wdata),
    .raddr_i (hi_raddr),
    .rdata_o (hi_rdata)
  );

  tplpq_ram #(.Width(tplpq_pkg::IdW), .Depth(QUEUE_DEPTH)) u_medium_ram (
    .clk_i   (clk_i),
    .we_i    (md_we),
    .waddr_i (add_slot),
    .wdata_i (id_q),
    .raddr_i (head_q[1]),
    .rdata_o (md_rdata)
  );

  tplpq_ram #(.Width(tplpq_pkg::IdW), .Depth(QUEUE_DEPTH)) u_low_ram (
    .clk_i   (clk_i),
    .we_i    (lo_we),
    .waddr_i (add_slot),
    .wdata_i (id_q),
    .raddr_i (head_q[2]),
    .rdata_o (lo_rdata)
  );

  // bookkeeping and result next values
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    sel_d     = sel_q;
    idx_d     = idx_q;
    kept_d    = kept_q;
    drop_d    = drop_q;
    status_d  = status_q;
    taken_d   = taken_q;
    expired_d = expired_q;

    if (cmd_i.exec) begin
      status_d  = tplpq_pkg::STAT_OK;
      taken_d   = '0;
      expired_d = '0;
      case (mode_q)
        tplpq_pkg::MODE_ADD: begin
          if (add_full) begin
            status_d = tplpq_pkg::STAT_FULL;
          end else begin
            count_d[lvl_q] = count_q[lvl_q] + CW'(1);
          end
        end
        tplpq_pkg::MODE_TAKE: begin
          if (take_hit) begin
            sel_d             = take_sel;
            head_d[take_sel]  = wrap_add(head_q[take_sel], CW'(1));
            count_d[take_sel] = count_q[take_sel] - CW'(1);
          end else begin
            status_d = tplpq_pkg::STAT_EMPTY;
          end
        end
        tplpq_pkg::MODE_TICK: begin
          idx_d  = '0;
          kept_d = '0;
          drop_d = '0;
        end
        default: ;
      endcase
    end

    // dequeued identifier from the selected store
    if (cmd_i.take_cap) begin
      case (sel_q)
        tplpq_pkg::LvlHigh:   taken_d = hi_rdata[HW-1:tplpq_pkg::TurnW];
        tplpq_pkg::LvlMedium: taken_d = md_rdata;
        default:              taken_d = lo_rdata;
      endcase
    end

    // tick walk
    if (cmd_i.tick_rd) begin
      idx_d = idx_q + CW'(1);
    end
    if (cmd_i.tick_wr) begin
      if (rd_expired) begin
        drop_d = drop_q + CW'(1);
      end else begin
        kept_d = kept_q + CW'(1);
      end
    end
    if (cmd_i.tick_fin) begin
      count_d[0] = kept_q;
      expired_d  = tplpq_pkg::ExpiredW'(drop_q);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
      idx_q  <= '0;
      kept_q <= '0;
      drop_q <= '0;
      sel_q  <= tplpq_pkg::LvlHigh;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      kept_q  <= kept_d;
      drop_q  <= drop_d;
      sel_q   <= sel_d;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    taken_q   <= taken_d;
    expired_q <= expired_d;
  end

  // outputs
  assign status_o          = status_q;
  assign taken_id_o        = taken_q;
  assign expired_count_o   = expired_q;
  assign nonempty_levels_o = tplpq_pkg::NonEmptyW'(count_q[0] != '0)
                           + tplpq_pkg::NonEmptyW'(count_q[1] != '0)
                           + tplpq_pkg::NonEmptyW'(count_q[2] != '0);

  assign stat_o.mode     = mode_q;
  assign stat_o.take_hit = take_hit;
  assign stat_o.tick_end = (idx_q == count_q[0]);

  // fill counts stay within the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q[0] <= DepthC) && (count_q[1] <= DepthC) && (count_q[2] <= DepthC))
    else $error("queue fill count beyond depth");

  // outside a keep/drop step every visited high entry is either kept or dropped
  a_tick_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.tick_wr |-> ((CW+1)'(kept_q) + (CW+1)'(drop_q) == (CW+1)'(idx_q)))
    else $error("tick walk lost an entry");

  // tick walk never passes the high fill count
  a_tick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick_rd |-> (idx_q < count_q[0]))
    else $error("tick read beyond the high queue");

  // a take that hits removes exactly one entry
  a_take_removes_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (mode_q == tplpq_pkg::MODE_TAKE) && take_hit) |=>
      ((CW+2)'(count_q[0]) + (CW+2)'(count_q[1]) + (CW+2)'(count_q[2]) + (CW+2)'(1)
       == $past((CW+2)'(count_q[0]) + (CW+2)'(count_q[1]) + (CW+2)'(count_q[2]))))
    else $error("take did not remove exactly one entry");

endmodule

`default_nettype wire

// ===== hw/rtl/three_level_priority_queue_with_expiry.sv =====
// ----------------------------------------------------------------------------
// three_level_priority_queue_with_expiry
// Three strict-priority FIFO levels of item identifiers; high entries carry
// a turn count that a tick decrements, dropping entries that run out.
//
//   channel   handshake          fields
//   -------   ---------------    ------------------------------------------
//   command   start / busy       mode_i item_id_i level_i turns_allowed_i
//   result    valid_o strobe     status_o taken_id_o expired_count_o
//                                nonempty_levels_o
//
// An add, an unused mode or a take on empty levels answers straight after
// decode, a take that hits after a wait state for the registered read, a
// tick after a read step and a keep/drop step per high entry of the walk over
// the registered-read high store. A new transaction is taken in the result
// cycle. Reset clears the heads and fill counts at once; the stores need no
// clearing. The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_priority_queue_with_expiry #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [tplpq_pkg::ModeW-1:0]     mode_i,
  input  wire logic [tplpq_pkg::IdW-1:0]       item_id_i,
  input  wire logic [tplpq_pkg::LevelW-1:0]    level_i,
  input  wire logic [tplpq_pkg::TurnW-1:0]     turns_allowed_i,
  output logic                                 valid_o,
  output logic      [tplpq_pkg::StatusW-1:0]   status_o,
  output logic      [tplpq_pkg::IdW-1:0]       taken_id_o,
  output logic      [tplpq_pkg::ExpiredW-1:0]  expired_count_o,
  output logic      [tplpq_pkg::NonEmptyW-1:0] nonempty_levels_o
);

  tplpq_pkg::cmd_t     cmd;
  tplpq_pkg::dp_stat_t stat;

  // controller
  tplpq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .valid_o (valid_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // datapath
  tplpq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .mode_i            (mode_i),
    .item_id_i         (item_id_i),
    .level_i           (level_i),
    .turns_allowed_i   (turns_allowed_i),
    .status_o          (status_o),
    .taken_id_o        (taken_id_o),
    .expired_count_o   (expired_count_o),
    .nonempty_levels_o (nonempty_levels_o)
  );

endmodule

`default_nettype wire

// ===== verif/tplpq_result_checker.sv =====
// ----------------------------------------------------------------------------
// tplpq_result_checker
// Watches the command and result channels of the three-level priority queue,
// keeps its own copy of the three levels and the high-entry turn counts,
// works out the answer of every accepted transaction and compares each result
// strobe, field by field, with the oldest answer still owed.
// ----------------------------------------------------------------------------
module tplpq_result_checker import tplpq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [ModeW-1:0]     mode_i,
  input  logic [IdW-1:0]       item_id_i,
  input  logic [LevelW-1:0]    level_i,
  input  logic [TurnW-1:0]     turns_allowed_i,
  input  logic                 res_valid_i,
  input  logic [StatusW-1:0]   status_i,
  input  logic [IdW-1:0]       taken_id_i,
  input  logic [ExpiredW-1:0]  expired_count_i,
  input  logic [NonEmptyW-1:0] nonempty_levels_i,
  output int unsigned          pending_o,
  output int unsigned          mismatches_o,
  output int unsigned          full_seen_o,
  output int unsigned          empty_seen_o,
  output int unsigned          dropped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // one answer owed by the block
  typedef struct packed {
    status_e               status;
    logic [IdW-1:0]        taken_id;
    logic [ExpiredW-1:0]   expired;
    logic [NonEmptyW-1:0]  nonempty;
  } answer_t;

  answer_t owed_q[$];

  // shadow of the three levels
  logic [IdW-1:0]   id_store   [3][QUEUE_DEPTH];
  logic [TurnW-1:0] turn_store [QUEUE_DEPTH];
  int unsigned      head       [3];
  int unsigned      fill       [3];
  int unsigned      miss_n;

  // apply one transaction to the shadow levels and return its answer
  function automatic answer_t apply_transaction(logic [ModeW-1:0] mode,
      logic [IdW-1:0] id, logic [LevelW-1:0] level, logic [TurnW-1:0] turns);
    answer_t     a;
    int unsigned lv;
    int unsigned slot;
    int unsigned src;
    int unsigned dst;
    int unsigned kept;
    int unsigned dropped;
    int unsigned busy_levels;
    a        = '0;
    a.status = STAT_OK;
    case (mode)
      MODE_ADD: begin
        // the spare level code lands in the low queue
        lv = (level == LvlSpare) ? LvlLow : level;
        if (fill[lv] >= QUEUE_DEPTH) begin
          a.status = STAT_FULL;
        end else begin
          slot = (head[lv] + fill[lv]) % QUEUE_DEPTH;
          id_store[lv][slot] = id;
          if (lv == LvlHigh) turn_store[slot] = turns;
          fill[lv]++;
        end
      end
      MODE_TAKE: begin
        a.status = STAT_EMPTY;
        for (int l = 0; l < 3; l++) begin
          if (a.status == STAT_EMPTY && fill[l] != 0) begin
            a.status   = STAT_OK;
            a.taken_id = id_store[l][head[l]];
            head[l]    = (head[l] + 1) % QUEUE_DEPTH;
            fill[l]--;
          end
        end
      end
      MODE_TICK: begin
        // compact the high level in place, survivors keep their order
        kept    = 0;
        dropped = 0;
        for (int i = 0; i < fill[LvlHigh]; i++) begin
          src = (head[LvlHigh] + i) % QUEUE_DEPTH;
          if (turn_store[src] <= 1) begin
            dropped++;
          end else begin
            dst = (head[LvlHigh] + kept) % QUEUE_DEPTH;
            id_store[LvlHigh][dst] = id_store[LvlHigh][src];
            turn_store[dst]        = turn_store[src] - 1'b1;
            kept++;
          end
        end
        fill[LvlHigh] = kept;
        a.expired     = ExpiredW'(dropped);
      end
      default: ;
    endcase
    busy_levels = 0;
    for (int l = 0; l < 3; l++) if (fill[l] != 0) busy_levels++;
    a.nonempty = NonEmptyW'(busy_levels);
    return a;
  endfunction

  // result compare first, since it always answers an earlier transaction
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    answer_t fresh;
    if (!rst_ni) begin
      for (int l = 0; l < 3; l++) begin
        head[l] = 0;
        fill[l] = 0;
      end
      owed_q.delete();
      miss_n = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
      full_seen_o  <= 0;
      empty_seen_o <= 0;
      dropped_o    <= 0;
    end else begin
      if (res_valid_i) begin
        if (owed_q.size() == 0) begin
          if (miss_n < 10)
            $display("%0t: result with nothing owed: status %0d id %h expired %0d levels %0d",
                     $time, status_i, taken_id_i, expired_count_i, nonempty_levels_i);
          miss_n++;
        end else begin
          want = owed_q.pop_front();
          if (status_i !== want.status || taken_id_i !== want.taken_id ||
              expired_count_i !== want.expired || nonempty_levels_i !== want.nonempty) begin
            if (miss_n < 10)
              $display("%0t: mismatch, expected status %0d id %h expired %0d levels %0d, got status %0d id %h expired %0d levels %0d",
                       $time, want.status, want.taken_id, want.expired, want.nonempty,
                       status_i, taken_id_i, expired_count_i, nonempty_levels_i);
            miss_n++;
          end
        end
      end
      if (start_i && !busy_i) begin
        fresh = apply_transaction(mode_i, item_id_i, level_i, turns_allowed_i);
        owed_q.push_back(fresh);
        if (fresh.status == STAT_FULL) full_seen_o <= full_seen_o + 1;
        if (fresh.status == STAT_EMPTY) empty_seen_o <= empty_seen_o + 1;
        dropped_o <= dropped_o + fresh.expired;
      end
      pending_o    <= owed_q.size();
      mismatches_o <= miss_n;
    end
  end

endmodule

// ===== verif/three_level_priority_queue_with_expiry_tb.sv =====
// ----------------------------------------------------------------------------
// three_level_priority_queue_with_expiry_tb
// Drives add, take, tick and unused-mode transactions into the priority queue:
// a directed opening on empty levels and field extremes, then bursts that fill one
// level, drain, churn the high level against ticks, or send raw noise, with
// random sender gaps. The result checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module three_level_priority_queue_with_expiry_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tplpq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 800;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [ModeW-1:0]     mode_i = MODE_NOP;
  logic [IdW-1:0]       item_id_i = '0;
  logic [LevelW-1:0]    level_i = LvlHigh;
  logic [TurnW-1:0]     turns_allowed_i = '0;
  logic                 valid_o;
  logic [StatusW-1:0]   status_o;
  logic [IdW-1:0]       taken_id_o;
  logic [ExpiredW-1:0]  expired_count_o;
  logic [NonEmptyW-1:0] nonempty_levels_o;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned full_seen;
  int unsigned empty_seen;
  int unsigned dropped;

  int unsigned add_n;
  int unsigned take_n;
  int unsigned tick_n;
  int unsigned nop_n;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  three_level_priority_queue_with_expiry #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .item_id_i        (item_id_i),
    .level_i          (level_i),
    .turns_allowed_i  (turns_allowed_i),
    .valid_o          (valid_o),
    .status_o         (status_o),
    .taken_id_o       (taken_id_o),
    .expired_count_o  (expired_count_o),
    .nonempty_levels_o(nonempty_levels_o)
  );

  tplpq_result_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .mode_i           (mode_i),
    .item_id_i        (item_id_i),
    .level_i          (level_i),
    .turns_allowed_i  (turns_allowed_i),
    .res_valid_i      (valid_o),
    .status_i         (status_o),
    .taken_id_i       (taken_id_o),
    .expired_count_i  (expired_count_o),
    .nonempty_levels_i(nonempty_levels_o),
    .pending_o        (pending),
    .mismatches_o     (mismatches),
    .full_seen_o      (full_seen),
    .empty_seen_o     (empty_seen),
    .dropped_o        (dropped)
  );

  // present one transaction and hold it until the block takes it
  task automatic issue(mode_e m, logic [IdW-1:0] id, logic [LevelW-1:0] lv,
                       logic [TurnW-1:0] t);
    start           <= 1'b1;
    mode_i          <= m;
    item_id_i       <= id;
    level_i         <= lv;
    turns_allowed_i <= t;
    do @(posedge clk_i); while (busy);
    case (m)
      MODE_ADD:  add_n++;
      MODE_TAKE: take_n++;
      MODE_TICK: tick_n++;
      default:   nop_n++;
    endcase
  endtask

  // sender idles for a number of cycles
  task automatic hold_off(int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // sender idles until every owed result has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // gap length: none, short, or mostly short with the odd long one
  function automatic int unsigned pick_gap(int unsigned style);
    if (style == 0) return 0;
    if (style == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 3);
  endfunction

  // turn counts, mostly small so that ticks expire entries
  function automatic logic [TurnW-1:0] pick_turns();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return TurnW'($urandom_range(0, 255));
      default: return TurnW'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [IdW-1:0] pick_id();
    return IdW'($urandom);
  endfunction

  // stimulus
  initial begin
    int unsigned flavor;
    int unsigned style;
    int unsigned burst;
    int unsigned sel;
    int unsigned opening;
    logic [LevelW-1:0] lv;
    add_n  = 0;
    take_n = 0;
    tick_n = 0;
    nop_n  = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening: empty take and tick, unused mode, turn extremes
    issue(MODE_TAKE, '1, LvlLow, '1);
    issue(MODE_TICK, '0, LvlHigh, '0);
    issue(MODE_NOP, 16'hC3C3, LvlSpare, 8'hFF);
    issue(MODE_ADD, 16'h0000, LvlHigh, 8'd0);
    issue(MODE_ADD, 16'hFFFF, LvlHigh, 8'd255);
    issue(MODE_ADD, 16'h1234, LvlHigh, 8'd1);
    issue(MODE_ADD, 16'h8001, LvlHigh, 8'd2);
    // zero and one turn both expire here
    issue(MODE_TICK, '0, LvlHigh, '0);
    issue(MODE_ADD, 16'hA5A5, LvlMedium, 8'd0);
    issue(MODE_ADD, 16'h5A5A, LvlLow, 8'd7);
    // spare level code goes to the low queue
    issue(MODE_ADD, 16'h0F0F, LvlSpare, 8'h80);
    issue(MODE_NOP, '0, LvlHigh, '0);
    issue(MODE_TICK, '1, LvlSpare, '1);
    issue(MODE_TAKE, '0, LvlHigh, '0);
    issue(MODE_TAKE, '0, LvlHigh, '0);
    issue(MODE_TAKE, '0, LvlHigh, '0);
    issue(MODE_TAKE, '0, LvlHigh, '0);
    issue(MODE_TAKE, '0, LvlHigh, '0);
    issue(MODE_ADD, 16'h7FFF, LvlMedium, 8'h7F);
    issue(MODE_TAKE, '0, LvlHigh, '0);
    wait_drained();
    opening = add_n + take_n + tick_n;

    // random bursts
    while (add_n + take_n + tick_n - opening < RANDOM_ITEMS) begin
      flavor = $urandom_range(0, 9);
      style  = $urandom_range(0, 2);
      if (flavor <= 2) begin
        // fill one level, often past full
        lv    = LevelW'($urandom_range(0, 3));
        burst = $urandom_range(14, 20);
        repeat (burst) begin
          issue(MODE_ADD, pick_id(), lv, pick_turns());
          hold_off(pick_gap(style));
        end
      end else if (flavor <= 4) begin
        // drain, often past empty
        burst = $urandom_range(4, 20);
        repeat (burst) begin
          issue(MODE_TAKE, pick_id(), LevelW'($urandom_range(0, 3)), pick_turns());
          hold_off(pick_gap(style));
        end
      end else if (flavor <= 7) begin
        // high level churn against ticks
        burst = $urandom_range(10, 30);
        repeat (burst) begin
          sel = $urandom_range(0, 9);
          if (sel < 4)
            issue(MODE_ADD, pick_id(), LvlHigh, pick_turns());
          else if (sel < 5)
            issue(MODE_ADD, pick_id(), LevelW'($urandom_range(0, 3)), pick_turns());
          else if (sel < 8)
            issue(MODE_TICK, pick_id(), LevelW'($urandom_range(0, 3)), pick_turns());
          else
            issue(MODE_TAKE, pick_id(), LevelW'($urandom_range(0, 3)), pick_turns());
          hold_off(pick_gap(style));
        end
      end else if (flavor == 8) begin
        // raw noise on every field
        burst = $urandom_range(5, 15);
        repeat (burst) begin
          issue(mode_e'($urandom_range(0, 3)), pick_id(), LevelW'($urandom_range(0, 3)),
                TurnW'($urandom_range(0, 255)));
          hold_off(pick_gap(style));
        end
      end else begin
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          issue(MODE_TICK, pick_id(), LevelW'($urandom_range(0, 3)), pick_turns());
          hold_off(pick_gap(style));
        end
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    // let the last results land, then give the verdict
    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("covered %0d adds (%0d refused on a full level), %0d takes (%0d on empty levels)",
             add_n, full_seen, take_n, empty_seen);
    $display("covered %0d ticks expiring %0d high entries, %0d unused-mode transactions",
             tick_n, dropped, nop_n);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tplpq_pkg.sv
hw/rtl/tplpq_ram.sv
hw/rtl/tplpq_ctrl.sv
hw/rtl/tplpq_dp.sv
hw/rtl/three_level_priority_queue_with_expiry.sv
verif/tplpq_result_checker.sv
verif/three_level_priority_queue_with_expiry_tb.sv
